>>> hdl/grid_window_vote_peak_assert.svh
// ----------------------------------------------------------------------------
// grid_window_vote_peak assertion macros
// Property wrappers shared by the checker; all sample on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_WINDOW_VOTE_PEAK_ASSERT_SVH
`define GRID_WINDOW_VOTE_PEAK_ASSERT_SVH

// same-cycle implication
`define GWVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWVP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gwvp_pkg.sv
// ----------------------------------------------------------------------------
// gwvp_pkg
// Shared widths, defaults and sequencer states of the grid window vote block.
// ----------------------------------------------------------------------------
package gwvp_pkg;

  localparam int GRID_SIZE_DEF = 1024;
  localparam int CELL_BITS_DEF = 32;

  localparam int COORD_W  = 11;
  localparam int WEIGHT_W = 16;
  localparam int RADIUS_W = 10;
  localparam int VALUE_W  = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gwvp_state_t;

endpackage

>>> hdl/gwvp_in_if.sv
// ----------------------------------------------------------------------------
// gwvp_in_if
// Point channel: valid/ready with position and weight.
// ----------------------------------------------------------------------------
interface gwvp_in_if;

  logic                             valid;
  logic                             ready;
  logic [gwvp_pkg::COORD_W-1:0]     point_x;
  logic [gwvp_pkg::COORD_W-1:0]     point_y;
  logic [gwvp_pkg::WEIGHT_W-1:0]    weight;

  modport source (output valid, output point_x, output point_y, output weight,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input weight,
                  output ready);

endinterface

>>> hdl/gwvp_out_if.sv
// ----------------------------------------------------------------------------
// gwvp_out_if
// Peak channel: valid/ready with peak position and value.
// ----------------------------------------------------------------------------
interface gwvp_out_if;

  logic                           valid;
  logic                           ready;
  logic [gwvp_pkg::COORD_W-1:0]   peak_x;
  logic [gwvp_pkg::COORD_W-1:0]   peak_y;
  logic [gwvp_pkg::VALUE_W-1:0]   peak_value;

  modport source (output valid, output peak_x, output peak_y, output peak_value,
                  input ready);
  modport sink   (input valid, input peak_x, input peak_y, input peak_value,
                  output ready);

endinterface

>>> hdl/gwvp_cell_ram.sv
// ----------------------------------------------------------------------------
// gwvp_cell_ram
// Vote cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gwvp_cell_ram #(
  parameter int AW = 20,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> hdl/grid_window_vote_peak.sv
// ----------------------------------------------------------------------------
// grid_window_vote_peak
// Windowed vote accumulator over a square grid with a running peak.
// ----------------------------------------------------------------------------
// Each point transfer adds its weight, with saturation, to every cell of the
// square window of half width radius around the point, clipped to 1..GRID_SIZE
// on both axes, and then returns the running peak (x, y, value) as one result.
// Cells go through a single read-modify-write unit one per cycle, x outer and
// y inner; in ready stays low from a point's transfer until its peak is
// loaded into the output register. The cell store's single read and single
// write port sets that pace. After reset the block runs a clearing pass over
// the whole cell store with in ready low; radius writes are taken during it.
// A finished peak sits in an output register, so the next point may transfer
// while it waits. Write radius only while the block is idle.
// ----------------------------------------------------------------------------
module grid_window_vote_peak #(
  parameter int GRID_SIZE = gwvp_pkg::GRID_SIZE_DEF,
  parameter int CELL_BITS = gwvp_pkg::CELL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gwvp_in_if.sink                       in_pt,
  gwvp_out_if.source                    out_pk,
  input  logic                          cfg_wr_en,
  input  logic [gwvp_pkg::RADIUS_W-1:0] cfg_wr_data
);

  // per-axis cell index bits, coordinate bits, window math bits
  localparam int IW   = $clog2(GRID_SIZE);
  localparam int CW   = $clog2(GRID_SIZE + 1);
  localparam int SW   = (CW > 12) ? CW : 12;
  localparam int AW   = 2 * IW;
  localparam int SUMW = ((CELL_BITS > gwvp_pkg::WEIGHT_W) ? CELL_BITS
                                                         : gwvp_pkg::WEIGHT_W) + 1;
  localparam logic [CELL_BITS-1:0] CELL_MAX = '1;

  gwvp_pkg::gwvp_state_t state_r, state_nxt;

  logic [gwvp_pkg::RADIUS_W-1:0] radius_r;

  // clearing pass
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // window bounds and scan position
  logic [SW-1:0] x_hi_r, y_lo_r, y_hi_r;
  logic [SW-1:0] k_r, l_r, k_nxt, l_nxt;
  logic [gwvp_pkg::WEIGHT_W-1:0] weight_r;

  // read stage: address and coordinates of the cell whose data returns
  logic          rd_vld_r;
  logic [AW-1:0] rd_addr_r;
  logic [CW-1:0] rd_k_r, rd_l_r;

  // running peak
  logic [CW-1:0]        best_x_r, best_y_r, best_x_nxt, best_y_nxt;
  logic [CELL_BITS-1:0] best_val_r, best_val_nxt;

  // result register
  logic                           out_vld_r, out_vld_nxt;
  logic [gwvp_pkg::COORD_W-1:0]   out_x_r, out_y_r;
  logic [gwvp_pkg::VALUE_W-1:0]   out_val_r;

  // RAM ports
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  // window setup from the incoming point
  logic [SW-1:0] px_s, py_s, r_s;
  logic [SW-1:0] wx_lo, wx_hi, wy_lo, wy_hi;
  logic          win_empty;

  // accumulate unit
  logic [SUMW-1:0]      cell_sum;
  logic [CELL_BITS-1:0] cell_new;

  logic in_xfer, out_load, scan_last;

  function automatic logic [SW-1:0] clip_lo(input logic [SW-1:0] c,
                                            input logic [SW-1:0] r);
    clip_lo = (c > r) ? (c - r) : SW'(1);
  endfunction

  function automatic logic [SW-1:0] clip_hi(input logic [SW-1:0] c,
                                            input logic [SW-1:0] r);
    logic [SW-1:0] v;
    v = c + r;
    clip_hi = (v > SW'(GRID_SIZE)) ? SW'(GRID_SIZE) : v;
  endfunction

  assign px_s  = SW'(in_pt.point_x);
  assign py_s  = SW'(in_pt.point_y);
  assign r_s   = SW'(radius_r);
  assign wx_lo = clip_lo(px_s, r_s);
  assign wx_hi = clip_hi(px_s, r_s);
  assign wy_lo = clip_lo(py_s, r_s);
  assign wy_hi = clip_hi(py_s, r_s);
  // far outside the grid, or coordinate zero with radius zero
  assign win_empty = (wx_lo > wx_hi) || (wy_lo > wy_hi);

  assign in_xfer   = in_pt.valid && in_pt.ready;
  assign scan_last = (k_r == x_hi_r) && (l_r == y_hi_r);

  // saturating add on the cell coming back from the RAM
  assign cell_sum = SUMW'(ram_rdata) + SUMW'(weight_r);
  assign cell_new = (cell_sum > SUMW'(CELL_MAX)) ? CELL_MAX : CELL_BITS'(cell_sum);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gwvp_pkg::ST_CLEAR: begin
        if (&clr_addr_r) state_nxt = gwvp_pkg::ST_IDLE;
      end
      gwvp_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = win_empty ? gwvp_pkg::ST_DONE : gwvp_pkg::ST_SCAN;
      end
      gwvp_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = gwvp_pkg::ST_DRAIN;
      end
      gwvp_pkg::ST_DRAIN: begin
        state_nxt = gwvp_pkg::ST_DONE;
      end
      gwvp_pkg::ST_DONE: begin
        if (!out_vld_r || out_pk.ready) state_nxt = gwvp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gwvp_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_pt.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_r;
    ram_wdata   = cell_new;
    out_load    = 1'b0;
    case (state_r)
      gwvp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      gwvp_pkg::ST_IDLE: begin
        in_pt.ready = 1'b1;
      end
      gwvp_pkg::ST_SCAN: begin
        ram_re = 1'b1;
        ram_we = rd_vld_r;
      end
      gwvp_pkg::ST_DRAIN: begin
        ram_we = rd_vld_r;
      end
      gwvp_pkg::ST_DONE: begin
        out_load = !out_vld_r || out_pk.ready;
      end
      default: begin
        in_pt.ready = 1'b0;
      end
    endcase
  end

  // cell address: (x-1) in the upper half, (y-1) in the lower half
  assign ram_raddr = {IW'(k_r - SW'(1)), IW'(l_r - SW'(1))};

  // ---------------------------------------------------------------- datapath
  always_comb begin
    clr_addr_nxt = clr_addr_r + AW'(1);

    k_nxt = k_r;
    l_nxt = l_r;
    if (state_r == gwvp_pkg::ST_SCAN) begin
      if (l_r == y_hi_r) begin
        l_nxt = y_lo_r;
        k_nxt = k_r + SW'(1);
      end else begin
        l_nxt = l_r + SW'(1);
      end
    end

    // strictly greater wins; a tie wins only with a smaller x
    best_x_nxt   = best_x_r;
    best_y_nxt   = best_y_r;
    best_val_nxt = best_val_r;
    if (ram_we && rd_vld_r) begin
      if (cell_new > best_val_r) begin
        best_x_nxt   = rd_k_r;
        best_y_nxt   = rd_l_r;
        best_val_nxt = cell_new;
      end else if ((cell_new == best_val_r) && (rd_k_r < best_x_r)) begin
        best_x_nxt = rd_k_r;
        best_y_nxt = rd_l_r;
      end
    end

    out_vld_nxt = out_vld_r;
    if (out_load)          out_vld_nxt = 1'b1;
    else if (out_pk.ready) out_vld_nxt = 1'b0;
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gwvp_pkg::ST_CLEAR;
      radius_r   <= gwvp_pkg::RADIUS_RST;
      clr_addr_r <= '0;
      rd_vld_r   <= 1'b0;
      best_x_r   <= '0;
      best_y_r   <= '0;
      best_val_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr_en) radius_r <= cfg_wr_data;
      if (state_r == gwvp_pkg::ST_CLEAR) clr_addr_r <= clr_addr_nxt;
      rd_vld_r   <= (state_r == gwvp_pkg::ST_SCAN);
      best_x_r   <= best_x_nxt;
      best_y_r   <= best_y_nxt;
      best_val_r <= best_val_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_hi_r   <= wx_hi;
      y_lo_r   <= wy_lo;
      y_hi_r   <= wy_hi;
      k_r      <= wx_lo;
      l_r      <= wy_lo;
      weight_r <= in_pt.weight;
    end else begin
      k_r <= k_nxt;
      l_r <= l_nxt;
    end
    rd_addr_r <= ram_raddr;
    rd_k_r    <= CW'(k_r);
    rd_l_r    <= CW'(l_r);
    if (out_load) begin
      out_x_r   <= gwvp_pkg::COORD_W'(best_x_r);
      out_y_r   <= gwvp_pkg::COORD_W'(best_y_r);
      out_val_r <= gwvp_pkg::VALUE_W'(best_val_r);
    end
  end

  assign out_pk.valid      = out_vld_r;
  assign out_pk.peak_x     = out_x_r;
  assign out_pk.peak_y     = out_y_r;
  assign out_pk.peak_value = out_val_r;

  gwvp_cell_ram #(
    .AW (AW),
    .DW (CELL_BITS)
  ) u_cell_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule

>>> hdl/gwvp_checker.sv
// ----------------------------------------------------------------------------
// gwvp_checker
// Port-level checks of the grid window vote block, bound to its top level.
// ----------------------------------------------------------------------------
`include "grid_window_vote_peak_assert.svh"

module gwvp_checker #(
  parameter int GRID_SIZE = gwvp_pkg::GRID_SIZE_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [gwvp_pkg::COORD_W-1:0] out_peak_x,
  input logic [gwvp_pkg::COORD_W-1:0] out_peak_y,
  input logic [gwvp_pkg::VALUE_W-1:0] out_peak_value
);

  // a point keeps the block busy in the cycle after its transfer
  `GWVP_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready right after point transfer")

  // peak position is either unset on both axes or set on both
  `GWVP_ASSERT_NOW(a_peak_pos_pair, out_valid && (GRID_SIZE < 2048), (out_peak_x == 0) == (out_peak_y == 0), "peak x/y half set")

  // result holds while stalled
  `GWVP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_peak_x) && $stable(out_peak_y) && $stable(out_peak_value), "stalled peak changed")

  `GWVP_ASSERT_NOW(a_out_known, out_valid, !$isunknown(out_peak_value), "peak value unknown")

endmodule

bind grid_window_vote_peak gwvp_checker #(
  .GRID_SIZE (GRID_SIZE)
) u_gwvp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pt.valid),
  .in_ready       (in_pt.ready),
  .out_valid      (out_pk.valid),
  .out_ready      (out_pk.ready),
  .out_peak_x     (out_pk.peak_x),
  .out_peak_y     (out_pk.peak_y),
  .out_peak_value (out_pk.peak_value)
);

>>> verif/tb_grid_window_vote_peak.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_window_vote_peak
// Self-checking bench for the windowed vote accumulator and its running peak.
// A tracker class keeps its own vote grid and peak. Every point transfer into
// the block is scored there and gives one expected peak. Every peak transfer
// out of the block is compared field by field with the oldest expected peak.
// Stimulus has a directed opening and randomized phases at several radius
// settings, one of them back to back.
// ----------------------------------------------------------------------------
module tb_grid_window_vote_peak;

  localparam int     GRID        = gwvp_pkg::GRID_SIZE_DEF;
  localparam int     CELL_W      = gwvp_pkg::CELL_BITS_DEF;
  // Watchdog limit, above the clearing pass plus the random phases.
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int     MAX_WEIGHT  = 65535;

  typedef logic [gwvp_pkg::COORD_W-1:0] coord_t;
  typedef logic [gwvp_pkg::VALUE_W-1:0] value_t;
  typedef bit   [CELL_W-1:0]            cell_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    value_t value;
  } peak_t;

  // --------------------------------------------------------------------------
  // Vote tracker: sparse copy of the grid, the running peak, and the peaks
  // still owed by the block.
  // --------------------------------------------------------------------------
  class vote_peak_tracker;
    cell_t cell_votes[int];
    int    radius;
    int    best_x;
    int    best_y;
    cell_t best_value;
    peak_t expected_peaks[$];
    int    mismatches;

    function new();
      radius     = int'(gwvp_pkg::RADIUS_RST);
      best_x     = 0;
      best_y     = 0;
      best_value = '0;
      mismatches = 0;
    endfunction

    // Score one accepted point over its clipped window, x outer, y inner.
    function void note_point(int px, int py, int w);
      int            x0, x1, y0, y1, k, l, key;
      bit [CELL_W:0] sum;
      cell_t         c;
      peak_t         pk;
      x0 = (px - radius >= 1) ? px - radius : 1;
      x1 = (px + radius <= GRID) ? px + radius : GRID;
      y0 = (py - radius >= 1) ? py - radius : 1;
      y1 = (py + radius <= GRID) ? py + radius : GRID;
      for (k = x0; k <= x1; k++) begin
        for (l = y0; l <= y1; l++) begin
          key = (k - 1) * GRID + (l - 1);
          c   = cell_votes.exists(key) ? cell_votes[key] : '0;
          sum = {1'b0, c} + w;
          c   = sum[CELL_W] ? '1 : sum[CELL_W-1:0];
          cell_votes[key] = c;
          if (c > best_value) begin
            best_x     = k;
            best_y     = l;
            best_value = c;
          end else if (c == best_value && k < best_x) begin
            best_x = k;
            best_y = l;
          end
        end
      end
      pk.x     = best_x[gwvp_pkg::COORD_W-1:0];
      pk.y     = best_y[gwvp_pkg::COORD_W-1:0];
      pk.value = best_value[gwvp_pkg::VALUE_W-1:0];
      expected_peaks.push_back(pk);
    endfunction

    function void check_peak(coord_t x, coord_t y, value_t value);
      peak_t want;
      if (expected_peaks.size() == 0) begin
        $error("peak transfer with no point pending: x=%0d y=%0d value=%0d",
               x, y, value);
        mismatches++;
        return;
      end
      want = expected_peaks.pop_front();
      if (x !== want.x) begin
        $error("peak_x: expected %0d, got %0d", want.x, x);
        mismatches++;
      end
      if (y !== want.y) begin
        $error("peak_y: expected %0d, got %0d", want.y, y);
        mismatches++;
      end
      if (value !== want.value) begin
        $error("peak_value: expected %0d, got %0d", want.value, value);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [gwvp_pkg::RADIUS_W-1:0] cfg_wr_data;

  gwvp_in_if  in_pt ();
  gwvp_out_if out_pk ();

  grid_window_vote_peak u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pt       (in_pt),
    .out_pk      (out_pk),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  vote_peak_tracker tracker;
  bit               no_idle = 1'b0;  // set for back-to-back stretches
  longint           cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: the run is bounded no matter what the block does.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Transfers are sampled on the rising edge; stimulus moves on the falling
  // edge, so nothing here races the block's own updates. Results are checked
  // before the same edge's point is scored; a point's peak can never come out
  // on the edge that takes the point in.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pk.valid === 1'b1 && out_pk.ready === 1'b1)
        tracker.check_peak(out_pk.peak_x, out_pk.peak_y, out_pk.peak_value);
      if (in_pt.valid === 1'b1 && in_pt.ready === 1'b1)
        tracker.note_point(int'(in_pt.point_x), int'(in_pt.point_y),
                           int'(in_pt.weight));
    end
  end

  // Peak sink: a random stall ahead of each result, none in back-to-back stretches,
  // then ready stays up until the transfer happens.
  initial begin : peak_sink
    int stall;
    out_pk.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_pk.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pk.ready <= 1'b1;
      do @(posedge clk); while (out_pk.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All of them are entered and left on a falling edge.
  // --------------------------------------------------------------------------

  // One point transfer after a random gap. Valid stays high on return so that
  // a gapless follow-up keeps it asserted without a glitch.
  task automatic send_point(input int px, input int py, input int w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pt.valid   <= 1'b1;
    in_pt.point_x <= px[gwvp_pkg::COORD_W-1:0];
    in_pt.point_y <= py[gwvp_pkg::COORD_W-1:0];
    in_pt.weight  <= w[gwvp_pkg::WEIGHT_W-1:0];
    do @(posedge clk); while (in_pt.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop sending and hold off until every owed peak has come back. Each point
  // gives exactly one peak, so the block is idle once the queue is empty.
  task automatic wait_drained();
    in_pt.valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_peaks.size() != 0) @(negedge clk);
  endtask

  // Radius write; only called with the block idle. The enable drops before any
  // following write raises it again.
  task automatic write_radius(input int r);
    cfg_wr_data <= r[gwvp_pkg::RADIUS_W-1:0];
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.radius = r;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random point sources
  // --------------------------------------------------------------------------

  // Mostly small weights so that cells collide on equal values and the
  // smaller-x tie rule gets real traffic; now and then the full range.
  function automatic int pick_weight();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_WEIGHT)
                                       : $urandom_range(0, 15);
  endfunction

  // Corner of a 16x16 cluster; some clusters hang over an edge of the grid.
  function automatic int cluster_base();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return GRID - 14;
      default: return $urandom_range(1, GRID - 24);
    endcase
  endfunction

  // Coordinates around and past the grid boundary.
  function automatic int rim_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return GRID - 1;
      4:       return GRID;
      5:       return GRID + 1;
      6:       return GRID + 2;
      default: return $urandom_range(GRID + 3, 2047);
    endcase
  endfunction

  // With a wide radius, keep the clipped window a few cells across by parking
  // the point far beyond the top edge; the last steps clip it away entirely.
  function automatic int far_coord(int r);
    int span;
    span = (GRID + 1 - r < 5) ? GRID + 1 - r : 5;
    return GRID - 2 + r + $urandom_range(0, span);
  endfunction

  // One radius setting, then a stream of points. Up to radius three most land in
  // a cluster so cells pile up and the peak moves; the rest probe the rim and
  // the whole coordinate range. Every hundredth point the sender drains the block.
  task automatic run_phase(input int r, input int count, input bit quiet);
    int bx, by, px, py, w, roll, i;
    write_radius(r);
    no_idle = quiet;
    bx = cluster_base();
    by = cluster_base();
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 9);
      if (r > 3) begin
        px = far_coord(r);
        py = far_coord(r);
        w  = (roll > 7) ? $urandom_range(0, MAX_WEIGHT) : pick_weight();
      end else if (roll < 7) begin
        px = bx + $urandom_range(0, 15);
        py = by + $urandom_range(0, 15);
        w  = pick_weight();
      end else if (roll == 7) begin
        px = rim_coord();
        py = rim_coord();
        w  = pick_weight();
      end else begin
        px = $urandom_range(0, 2047);
        py = $urandom_range(0, 2047);
        w  = $urandom_range(0, MAX_WEIGHT);
      end
      send_point(px, py, w);
      if (i % 100 == 99)
        wait_drained();
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    tracker       = new();
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_pt.valid   = 1'b0;
    in_pt.point_x = '0;
    in_pt.point_y = '0;
    in_pt.weight  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Radius left at its reset value of one. The first transfer sits out the
    // clearing pass.
    send_point(500, 500, 0);          // zero weight on an empty grid: no peak
    send_point(0, 0, 5);              // coordinate 0 folds to window 1..1
    wait_drained();

    // Single-cell windows: tie handling and empty windows.
    write_radius(0);
    send_point(10, 10, 100);
    send_point(3, 7, 100);            // equal value, smaller x: takes the peak
    send_point(8, 8, 100);            // equal value, larger x: ignored
    send_point(0, 5, 3);              // zero coordinate, zero radius: empty
    send_point(2047, 2047, 1);        // far off the grid: empty
    send_point(GRID, 1, MAX_WEIGHT);
    wait_drained();

    // Corners and clipping at radius one.
    write_radius(1);
    send_point(1, 1, MAX_WEIGHT);
    send_point(GRID, GRID, 1);
    send_point(GRID + 1, GRID + 1, 16'h5555);
    send_point(GRID + 2, 3, 16'hAAAA);  // clipped to nothing on x
    wait_drained();

    // Widest radius, points placed so the windows stay small.
    write_radius(1023);
    send_point(2047, 2047, 11);
    send_point(2046, 2047, 13);
    send_point(2047, 1985, 16'h8001);
    wait_drained();

    // Random phases over several radius settings, one of them back to back.
    run_phase(1, 350, 1'b0);
    run_phase(0, 300, 1'b1);
    run_phase(2, 300, 1'b0);
    run_phase(3, 250, 1'b0);
    run_phase(1023, 200, 1'b0);
    run_phase($urandom_range(4, 1022), 200, 1'b0);
    run_phase(1, 200, 1'b0);
    run_phase(1, 30, 1'b0);

    // Let any stray result show up before the verdict.
    repeat (40) @(negedge clk);
    if (tracker.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
